FILE: src/stoppable_fifo_server_macros.svh
// assertion macros for the stoppable fifo server
`ifndef STOPPABLE_FIFO_SERVER_MACROS_SVH
`define STOPPABLE_FIFO_SERVER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SFS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define SFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SFS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SFS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: src/sfs_pkg.sv
package sfs_pkg;

    // queue geometry
    localparam int DEPTH   = 16;
    localparam int DATA_W  = 32;
    localparam int TIMER_W = 16;
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam int SLOT_W  = $clog2(DEPTH);

    // operation codes
    typedef enum logic [1:0]
    {
        OP_TICK   = 2'd0,
        OP_PUSH   = 2'd1,
        OP_STOP   = 2'd2,
        OP_RESUME = 2'd3
    } op_t;

    // controls of one storage cell
    typedef struct packed
    {
        logic shift;
        logic load;
    } cell_ctl_t;

    // controls from the controller to the cell chain
    typedef struct packed
    {
        logic              pop;
        logic              push;
        logic [SLOT_W-1:0] slot;
    } chain_ctl_t;

endpackage

FILE: src/sfs_cell.sv
module sfs_cell
    import sfs_pkg::*;
(
    input  logic              clk,
    input  cell_ctl_t         ctl,
    input  logic [DATA_W-1:0] load_data,
    input  logic [DATA_W-1:0] next_data,
    output logic [DATA_W-1:0] data
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    // take the neighbor's item on a pop, a new item on a push
    always_comb
    begin
        data_next = data_reg;
        if (ctl.shift)
        begin
            data_next = next_data;
        end
        else if (ctl.load)
        begin
            data_next = load_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

FILE: src/sfs_ctrl.sv
module sfs_ctrl
    import sfs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [1:0]         opcode,
    input  logic [DATA_W-1:0]  head_data,
    input  logic               cfg_wr_en,
    input  logic [TIMER_W-1:0] cfg_wr_data,
    output chain_ctl_t         chain,
    output logic               done,
    output logic               departed,
    output logic [DATA_W-1:0]  departed_value,
    output logic               is_stopped,
    output logic [COUNT_W-1:0] occupancy,
    output logic               push_dropped
);

    logic [COUNT_W-1:0] count_reg, count_next;
    logic               paused_reg, paused_next;
    logic [TIMER_W-1:0] countdown_reg, countdown_next;
    logic               active_reg, active_next;
    logic [TIMER_W-1:0] prep_reg;
    logic               done_reg;
    logic               departed_reg, departed_next;
    logic [DATA_W-1:0]  dep_value_reg, dep_value_next;
    logic               dropped_reg, dropped_next;
    logic [TIMER_W-1:0] load_value;
    op_t                op;

    assign op         = op_t'(opcode);
    assign load_value = (prep_reg == '0) ? TIMER_W'(1) : prep_reg;

    // step of the queue and timer for one accepted item
    always_comb
    begin
        count_next     = count_reg;
        paused_next    = paused_reg;
        countdown_next = countdown_reg;
        active_next    = active_reg;
        departed_next  = 1'b0;
        dep_value_next = '0;
        dropped_next   = 1'b0;
        chain.pop      = 1'b0;
        chain.push     = 1'b0;
        chain.slot     = count_reg[SLOT_W-1:0];
        if (accept)
        begin
            case (op)
                OP_TICK:
                begin
                    if (!paused_reg && active_reg)
                    begin
                        if (countdown_reg > TIMER_W'(1))
                        begin
                            countdown_next = countdown_reg - TIMER_W'(1);
                        end
                        else if (count_reg != '0)
                        begin
                            departed_next  = 1'b1;
                            dep_value_next = head_data;
                            chain.pop      = 1'b1;
                            count_next     = count_reg - COUNT_W'(1);
                            if (count_reg > COUNT_W'(1))
                            begin
                                countdown_next = load_value;
                            end
                            else
                            begin
                                countdown_next = '0;
                                active_next    = 1'b0;
                            end
                        end
                        else
                        begin
                            countdown_next = '0;
                            active_next    = 1'b0;
                        end
                    end
                end
                OP_PUSH:
                begin
                    if (count_reg >= COUNT_W'(DEPTH))
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        chain.push = 1'b1;
                        count_next = count_reg + COUNT_W'(1);
                        if (count_reg == '0 && !paused_reg)
                        begin
                            countdown_next = load_value;
                            active_next    = 1'b1;
                        end
                    end
                end
                OP_STOP:
                begin
                    paused_next = 1'b1;
                end
                OP_RESUME:
                begin
                    paused_next = 1'b0;
                    if (!active_reg && count_reg != '0)
                    begin
                        countdown_next = load_value;
                        active_next    = 1'b1;
                    end
                end
                default:
                begin
                    paused_next = paused_reg;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            paused_reg    <= 1'b0;
            countdown_reg <= '0;
            active_reg    <= 1'b0;
            prep_reg      <= TIMER_W'(1);
            done_reg      <= 1'b0;
            departed_reg  <= 1'b0;
            dropped_reg   <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            paused_reg    <= paused_next;
            countdown_reg <= countdown_next;
            active_reg    <= active_next;
            done_reg      <= accept;
            departed_reg  <= departed_next;
            dropped_reg   <= dropped_next;
            if (cfg_wr_en)
            begin
                prep_reg <= cfg_wr_data;
            end
        end
    end

    // departed value register
    always_ff @(posedge clk)
    begin
        dep_value_reg <= dep_value_next;
    end

    assign done           = done_reg;
    assign departed       = departed_reg;
    assign departed_value = dep_value_reg;
    assign is_stopped     = paused_reg;
    assign occupancy      = count_reg;
    assign push_dropped   = dropped_reg;

endmodule

FILE: src/stoppable_fifo_server.sv
// channel   | transfer when      | signals
// ----------+--------------------+-----------------------------------------------
// command   | start && !busy     | opcode, item_value
// result    | done               | departed, departed_value, is_stopped,
//           |                    | occupancy, push_dropped
// config    | cfg_wr_en          | cfg_wr_data (preparation ticks)
//
// one command per cycle; busy stays low, the queue and timer settle in one step
// each result appears in the cycle after its command, for one cycle, on done
// the item chain shifts every cell toward the head in the same cycle as a pop
// reset clears count, timer and stop state; the item cells are not cleared
// the receiver cannot stall, results are never held
`include "stoppable_fifo_server_macros.svh"

module stoppable_fifo_server
    import sfs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         opcode,
    input  logic [DATA_W-1:0]  item_value,
    input  logic               cfg_wr_en,
    input  logic [TIMER_W-1:0] cfg_wr_data,
    output logic               done,
    output logic               departed,
    output logic [DATA_W-1:0]  departed_value,
    output logic               is_stopped,
    output logic [COUNT_W-1:0] occupancy,
    output logic               push_dropped
);

    logic              accept;
    chain_ctl_t        chain;
    logic [DATA_W-1:0] cell_data [DEPTH];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // queue and timer control
    sfs_ctrl u_ctrl
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .opcode         (opcode),
        .head_data      (cell_data[0]),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .chain          (chain),
        .done           (done),
        .departed       (departed),
        .departed_value (departed_value),
        .is_stopped     (is_stopped),
        .occupancy      (occupancy),
        .push_dropped   (push_dropped)
    );

    // chain of item cells, cell zero holds the head
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        cell_ctl_t         ctl;
        logic [DATA_W-1:0] next_data;

        assign ctl.shift = chain.pop;
        assign ctl.load  = chain.push && (chain.slot == SLOT_W'(i));

        if (i == DEPTH - 1)
        begin : g_last
            assign next_data = '0;
        end
        else
        begin : g_mid
            assign next_data = cell_data[i + 1];
        end

        sfs_cell u_cell
        (
            .clk       (clk),
            .ctl       (ctl),
            .load_data (item_value),
            .next_data (next_data),
            .data      (cell_data[i])
        );
    end

    // checks
    `SFS_ASSERT_NEXT(a_push_full_drops, clk, rst_n,
        accept && opcode == OP_PUSH && occupancy == COUNT_W'(DEPTH),
        done && push_dropped && occupancy == COUNT_W'(DEPTH))
    `SFS_ASSERT_NEXT(a_stop_holds, clk, rst_n,
        accept && opcode == OP_STOP, done && is_stopped && !departed)
    `SFS_ASSERT_NOW(a_depart_pops, clk, rst_n,
        departed, done && occupancy + COUNT_W'(1) == $past(occupancy))
    `SFS_ASSERT_NOW(a_result_only_on_done, clk, rst_n,
        departed || push_dropped, done && !(departed && push_dropped))

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import sfs_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    // one queued stimulus entry: a command, a register write, or a wait for idle
    typedef enum logic [1:0]
    {
        ITEM_CMD,
        ITEM_CFG,
        ITEM_SYNC
    } item_kind_t;

    typedef struct
    {
        item_kind_t        kind;
        op_t               op;
        logic [DATA_W-1:0] value;
    } backlog_item_t;

    // what one command should produce
    typedef struct packed
    {
        logic               departed;
        logic [DATA_W-1:0]  value;
        logic               stopped;
        logic [COUNT_W-1:0] occupancy;
        logic               dropped;
    } outcome_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         opcode = OP_TICK;
    logic [DATA_W-1:0]  item_value = '0;
    logic               cfg_wr_en = 1'b0;
    logic [TIMER_W-1:0] cfg_wr_data = '0;
    logic               done;
    logic               departed;
    logic [DATA_W-1:0]  departed_value;
    logic               is_stopped;
    logic [COUNT_W-1:0] occupancy;
    logic               push_dropped;

    backlog_item_t command_backlog[$];
    outcome_t      queue_outcomes[$];

    // shadow copy of the served queue
    logic [DATA_W-1:0]  q_store[DEPTH];
    logic [SLOT_W-1:0]  q_head = '0;
    logic [SLOT_W-1:0]  q_tail = '0;
    logic [COUNT_W-1:0] q_count = '0;
    logic               q_paused = 1'b0;
    logic [TIMER_W-1:0] q_timer = '0;
    logic               q_timer_on = 1'b0;
    logic [TIMER_W-1:0] q_prep = TIMER_W'(1);

    int n_fail = 0;
    int n_cmds = 0;
    int n_departed = 0;
    int n_dropped = 0;
    int n_cfg = 0;
    int cycle_count = 0;
    int gap_left = 0;
    int burst_left = 20;

    stoppable_fifo_server i_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .item_value     (item_value),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .done           (done),
        .departed       (departed),
        .departed_value (departed_value),
        .is_stopped     (is_stopped),
        .occupancy      (occupancy),
        .push_dropped   (push_dropped)
    );

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // a zero setting behaves as one tick
    function automatic logic [TIMER_W-1:0] reload_ticks();
        return (q_prep == '0) ? TIMER_W'(1) : q_prep;
    endfunction

    // advance the shadow queue by one command
    function automatic outcome_t serve_command(input op_t op, input logic [DATA_W-1:0] value);
        outcome_t r;
        r = '0;
        case (op)
            OP_TICK:
            begin
                if (!q_paused && q_timer_on)
                begin
                    if (q_timer > 1)
                        q_timer = q_timer - 1'b1;
                    else if (q_count > 0)
                    begin
                        r.departed = 1'b1;
                        r.value    = q_store[q_head];
                        q_head     = q_head + 1'b1;
                        q_count    = q_count - 1'b1;
                        if (q_count > 0)
                            q_timer = reload_ticks();
                        else
                        begin
                            q_timer    = '0;
                            q_timer_on = 1'b0;
                        end
                    end
                    else
                    begin
                        q_timer    = '0;
                        q_timer_on = 1'b0;
                    end
                end
            end
            OP_PUSH:
            begin
                if (q_count >= DEPTH)
                    r.dropped = 1'b1;
                else
                begin
                    // countdown starts only on a running empty queue
                    if (q_count == 0 && !q_paused)
                    begin
                        q_timer    = reload_ticks();
                        q_timer_on = 1'b1;
                    end
                    q_store[q_tail] = value;
                    q_tail          = q_tail + 1'b1;
                    q_count         = q_count + 1'b1;
                end
            end
            OP_STOP:
                q_paused = 1'b1;
            default:
            begin
                q_paused = 1'b0;
                if (!q_timer_on && q_count > 0)
                begin
                    q_timer    = reload_ticks();
                    q_timer_on = 1'b1;
                end
            end
        endcase
        r.stopped   = q_paused;
        r.occupancy = q_count;
        return r;
    endfunction

    // driver: launches commands and register writes from the backlog
    always @(posedge clk)
    begin
        logic          nxt_start;
        logic          nxt_cfg;
        backlog_item_t it;
        outcome_t      res;
        if (!rst_n)
        begin
            start     <= 1'b0;
            cfg_wr_en <= 1'b0;
        end
        else
        begin
            nxt_start = 1'b0;
            nxt_cfg   = 1'b0;
            // register write lands at this edge
            if (cfg_wr_en)
            begin
                q_prep = cfg_wr_data;
                n_cfg++;
            end
            // command transfer
            if (start && !busy)
            begin
                res = serve_command(op_t'(opcode), item_value);
                queue_outcomes.insert(queue_outcomes.size(), res);
                n_cmds++;
            end
            if (start && busy)
                nxt_start = 1'b1;
            else if (gap_left > 0)
                gap_left--;
            else if (command_backlog.size() > 0)
            begin
                it = command_backlog[0];
                if (it.kind == ITEM_CMD)
                begin
                    nxt_start = 1'b1;
                    opcode     <= it.op;
                    item_value <= it.value;
                    command_backlog.delete(0);
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        gap_left   = $urandom_range(1, 8);
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                                 : $urandom_range(1, 20);
                    end
                end
                else if (queue_outcomes.size() == 0 && !done && !start && !cfg_wr_en)
                begin
                    // block idle: write the register or just move on
                    if (it.kind == ITEM_CFG)
                    begin
                        nxt_cfg = 1'b1;
                        cfg_wr_data <= it.value[TIMER_W-1:0];
                    end
                    command_backlog.delete(0);
                end
            end
            start     <= nxt_start;
            cfg_wr_en <= nxt_cfg;
        end
    end

    task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            n_fail++;
        end
    endtask

    // monitor: compares each result with the oldest expectation
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && done)
        begin
            if (queue_outcomes.size() == 0)
            begin
                $error("result with no command outstanding");
                n_fail++;
            end
            else
            begin
                want = queue_outcomes[0];
                queue_outcomes.delete(0);
                check_field("departed", want.departed, departed);
                check_field("departed_value", want.value, departed_value);
                check_field("is_stopped", want.stopped, is_stopped);
                check_field("occupancy", want.occupancy, occupancy);
                check_field("push_dropped", want.dropped, push_dropped);
                if (want.departed)
                    n_departed++;
                if (want.dropped)
                    n_dropped++;
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("stoppable_fifo_server: mismatch");
            $finish;
        end
    end

    task automatic add_cmd(input op_t op, input logic [DATA_W-1:0] value);
        backlog_item_t it;
        it.kind  = ITEM_CMD;
        it.op    = op;
        it.value = value;
        command_backlog.insert(command_backlog.size(), it);
    endtask

    task automatic add_marker(input item_kind_t kind, input logic [DATA_W-1:0] value);
        backlog_item_t it;
        it.kind  = kind;
        it.op    = OP_TICK;
        it.value = value;
        command_backlog.insert(command_backlog.size(), it);
    endtask

    // random mix, push share in percent, stop 4 and resume 5 percent, ticks take what is left
    task automatic random_phase(input int count, input int push_pct);
        int               r;
        logic [DATA_W-1:0] v;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            case ($urandom_range(0, 9))
                0:       v = '0;
                1:       v = '1;
                default: v = $urandom;
            endcase
            if (r < push_pct)
                add_cmd(OP_PUSH, v);
            else if (r < push_pct + 4)
                add_cmd(OP_STOP, v);
            else if (r < push_pct + 9)
                add_cmd(OP_RESUME, v);
            else
                add_cmd(OP_TICK, v);
        end
    endtask

    // stimulus and end of run
    initial
    begin
        // directed: an idle tick and resume, stop twice, push while stopped, resume restart
        add_cmd(OP_TICK, '0);
        add_cmd(OP_RESUME, '0);
        add_cmd(OP_STOP, '0);
        add_cmd(OP_STOP, '0);
        add_cmd(OP_PUSH, '0);
        add_cmd(OP_TICK, '0);
        add_cmd(OP_RESUME, '0);
        add_cmd(OP_TICK, '0);
        // fill while stopped, then one push into a full queue
        add_cmd(OP_STOP, '0);
        add_cmd(OP_PUSH, '1);
        for (int i = 0; i < DEPTH; i++)
            add_cmd(OP_PUSH, $urandom);
        add_cmd(OP_TICK, '0);
        add_cmd(OP_RESUME, '0);
        add_cmd(OP_RESUME, '0);

        // random phases over several preparation settings
        add_marker(ITEM_CFG, 0);
        random_phase(300, 35);
        add_marker(ITEM_CFG, 1);
        random_phase(150, 30);
        add_marker(ITEM_SYNC, 0);
        random_phase(150, 30);
        add_marker(ITEM_CFG, 3);
        random_phase(300, 25);
        add_marker(ITEM_CFG, 2);
        random_phase(300, 20);
        add_marker(ITEM_CFG, $urandom_range(4, 12));
        random_phase(300, 15);
        add_marker(ITEM_CFG, 1);
        random_phase(300, 45);
        // longest setting last, the queue never needs to drain afterwards
        add_marker(ITEM_CFG, 16'hFFFF);
        random_phase(80, 50);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (command_backlog.size() != 0 || start || cfg_wr_en
               || queue_outcomes.size() != 0 || done)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (queue_outcomes.size() != 0)
        begin
            $error("%0d results never arrived", queue_outcomes.size());
            n_fail++;
        end

        $display("run covered %0d commands over %0d register writes", n_cmds, n_cfg);
        $display("  with %0d departures and %0d dropped pushes", n_departed, n_dropped);
        if (n_fail == 0)
            $display("stoppable_fifo_server: match");
        else
            $display("stoppable_fifo_server: mismatch");
        $finish;
    end

endmodule
